@@ rtl/core/ahcfr_pkg.sv @@
package ahcfr_pkg;

	localparam int unsigned MAX_FRAME_LEN_DEF = 1023;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned LEN_MAX = 1023;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [BYTE_W-1:0] RESP_START_RST = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_START_RST = 8'h1B;
	localparam logic [BYTE_W-1:0] END_CHAR_RST = 8'h0D;

	localparam logic [BYTE_W-1:0] HEX_DIGIT_BASE = 8'h30;
	localparam logic [BYTE_W-1:0] HEX_ALPHA_BASE = 8'h41;
	localparam logic [3:0] HEX_ALPHA_FIRST = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESP_START = 2'd0,
		REG_CMD_START  = 2'd1,
		REG_END_CHAR   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] resp_start;
		logic [BYTE_W-1:0] cmd_start;
		logic [BYTE_W-1:0] end_char;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] command_code;
		logic              is_command;
		logic [LEN_W-1:0]  frame_length;
		logic              checksum_ok;
		logic              frame_end;
		logic              stored;
		logic [BYTE_W-1:0] data_byte;
	} res_t;

	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		logic [BYTE_W-1:0] c;
		if (nib < HEX_ALPHA_FIRST) begin
			c = HEX_DIGIT_BASE + {4'd0, nib};
		end else begin
			c = HEX_ALPHA_BASE + {4'd0, nib - HEX_ALPHA_FIRST};
		end
		return c;
	endfunction

endpackage

@@ rtl/core/ascii_hex_checksum_frame_receiver.sv @@
// each accepted byte goes from the input register via the frame core to the output register
// throughput: one byte per cycle unless the master side stalls, set by the frame state update
// input and output registers decouple the sides; one byte is taken while a result waits
// reset: arst_n low clears frame state, pipeline valids and loads register reset values
module ascii_hex_checksum_frame_receiver
	import ahcfr_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,   // rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// data_byte[7:0], stored[8], checksum_ok[9], frame_length[19:10],
	// is_command[20], command_code[28:21], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,   // frame_end
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_wdata
);

	localparam int unsigned PAY_W = BYTE_W + 1 + 1 + LEN_W + 1 + BYTE_W;

	cfg_t              cfg;
	res_t              res;
	res_t              res_s2;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	logic              advance;
	logic              step;
	logic [PAY_W-1:0]  payload;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ahcfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ahcfr_frame_core #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign payload = {res_s2.command_code, res_s2.is_command, res_s2.frame_length,
		res_s2.checksum_ok, res_s2.stored, res_s2.data_byte};

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_DATA_W'(payload);
	assign m_axis_tlast  = res_s2.frame_end;

endmodule

@@ rtl/core/ahcfr_cfg_regs.sv @@
module ahcfr_cfg_regs
	import ahcfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_start <= RESP_START_RST;
			cfg_q.cmd_start  <= CMD_START_RST;
			cfg_q.end_char   <= END_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESP_START: cfg_q.resp_start <= cfg_wdata;
				REG_CMD_START:  cfg_q.cmd_start  <= cfg_wdata;
				REG_END_CHAR:   cfg_q.end_char   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/ahcfr_frame_core.sv @@
module ahcfr_frame_core
	import ahcfr_pkg::*;
#(
	parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              cfg,
	output res_t              res
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);
	localparam int unsigned EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic              in_frame_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] last_q;
	logic [BYTE_W-1:0] prior_q;
	logic [BYTE_W-1:0] first_q;
	logic [BYTE_W-1:0] second_q;

	logic              hit_start;
	logic              hit_end;
	logic              do_store;
	logic              do_close;
	logic [BYTE_W-1:0] body_sum;
	logic [EXT_W-1:0]  count_ext;
	logic              sum_match;

	assign hit_start = (rx_byte == cfg.resp_start) || (rx_byte == cfg.cmd_start);
	assign hit_end   = !hit_start && (rx_byte == cfg.end_char);
	assign do_store  = hit_start || (!hit_end && in_frame_q);
	assign do_close  = hit_end && (count_q != '0);

	// sum without the two trailing checksum characters
	assign body_sum  = sum_q - last_q - prior_q;
	assign sum_match = (prior_q == hex_char(body_sum[7:4])) &&
		(last_q == hex_char(body_sum[3:0]));
	assign count_ext = EXT_W'(count_q);

	always_comb begin
		res = '0;
		res.data_byte = rx_byte;
		res.stored    = do_store;
		res.frame_end = do_close;
		if (do_close) begin
			res.checksum_ok  = (count_q >= CNT_W'(3)) && sum_match;
			res.frame_length = (count_ext > EXT_W'(LEN_MAX)) ? LEN_W'(LEN_MAX)
				: count_ext[LEN_W-1:0];
			res.is_command   = (first_q == cfg.cmd_start) && (first_q != cfg.resp_start);
			res.command_code = (count_q >= CNT_W'(2)) ? second_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			sum_q      <= '0;
			last_q     <= '0;
			prior_q    <= '0;
			first_q    <= '0;
			second_q   <= '0;
		end else if (step) begin
			if (hit_start) begin
				in_frame_q <= 1'b1;
			end else if (hit_end) begin
				in_frame_q <= 1'b0;
			end
			if (do_store) begin
				if (count_q == '0) begin
					first_q <= rx_byte;
				end else if (count_q == CNT_W'(1)) begin
					second_q <= rx_byte;
				end
				prior_q <= last_q;
				last_q  <= rx_byte;
				sum_q   <= sum_q + rx_byte;
				if (count_q < CNT_W'(MAX_FRAME_LEN)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (do_close) begin
				count_q  <= '0;
				sum_q    <= '0;
				last_q   <= '0;
				prior_q  <= '0;
				first_q  <= '0;
				second_q <= '0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_LEN))
		else $error("frame count above limit");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (count_q == '0))
		else $error("bytes held outside a frame");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && do_close) |=> (count_q == '0) && (sum_q == '0) && !in_frame_q)
		else $error("frame state not cleared after close");

	a_ok_needs_three: assert property (@(posedge clk) disable iff (!arst_n)
		res.checksum_ok |-> res.frame_end && (count_q >= CNT_W'(3)))
		else $error("checksum pass on short or open frame");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import ahcfr_pkg::*;

	class frame_scoreboard;
		logic [BYTE_W-1:0] resp_char;
		logic [BYTE_W-1:0] cmd_char;
		logic [BYTE_W-1:0] end_char;

		bit                frame_open;
		int unsigned       stored_count;
		logic [BYTE_W-1:0] byte_sum;
		logic [BYTE_W-1:0] last_b;
		logic [BYTE_W-1:0] prior_b;
		logic [BYTE_W-1:0] first_b;
		logic [BYTE_W-1:0] second_b;

		res_t        expected_q[$];
		int unsigned errors;
		int unsigned requests;
		int unsigned frames_closed;
		int unsigned frames_good;
		int unsigned frames_long;

		function new();
			resp_char = RESP_START_RST;
			cmd_char = CMD_START_RST;
			end_char = END_CHAR_RST;
			frame_open = 1'b0;
			clear_frame();
		endfunction

		function void clear_frame();
			stored_count = 0;
			byte_sum = '0;
			last_b = '0;
			prior_b = '0;
			first_b = '0;
			second_b = '0;
		endfunction

		function logic [BYTE_W-1:0] hex_of(logic [3:0] nib);
			return (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
		endfunction

		function void set_reg(reg_idx_t idx, logic [BYTE_W-1:0] v);
			case (idx)
				REG_RESP_START: resp_char = v;
				REG_CMD_START:  cmd_char = v;
				REG_END_CHAR:   end_char = v;
				default: ;
			endcase
		endfunction

		function void append(logic [BYTE_W-1:0] b);
			if (stored_count == 0) begin
				first_b = b;
			end else if (stored_count == 1) begin
				second_b = b;
			end
			prior_b = last_b;
			last_b = b;
			byte_sum = byte_sum + b;
			if (stored_count < MAX_FRAME_LEN_DEF) begin
				stored_count++;
			end
		endfunction

		function void note_request(logic [BYTE_W-1:0] b);
			res_t              r;
			logic [BYTE_W-1:0] s;
			r = '0;
			r.data_byte = b;
			if (b == resp_char || b == cmd_char) begin
				frame_open = 1'b1;
				append(b);
				r.stored = 1'b1;
			end else if (b == end_char) begin
				frame_open = 1'b0;
				if (stored_count != 0) begin
					r.frame_end = 1'b1;
					if (stored_count >= 3) begin
						s = byte_sum - last_b - prior_b;
						r.checksum_ok = (prior_b == hex_of(s[7:4])) && (last_b == hex_of(s[3:0]));
					end
					r.frame_length = LEN_W'((stored_count > LEN_MAX) ? LEN_MAX : stored_count);
					r.is_command = (first_b == cmd_char) && (first_b != resp_char);
					r.command_code = (stored_count >= 2) ? second_b : '0;
					frames_closed++;
					if (r.checksum_ok) begin
						frames_good++;
					end
					if (stored_count >= MAX_FRAME_LEN_DEF) begin
						frames_long++;
					end
					clear_frame();
				end
			end else if (frame_open) begin
				append(b);
				r.stored = 1'b1;
			end
			expected_q = {expected_q, r};
			requests++;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] d, logic last);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing pending: data_byte %0d", d[7:0]);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("data_byte", want.data_byte, d[7:0]);
			compare_field("stored", want.stored, d[8]);
			compare_field("frame_end", want.frame_end, last);
			compare_field("checksum_ok", want.checksum_ok, d[9]);
			compare_field("frame_length", want.frame_length, d[19:10]);
			compare_field("is_command", want.is_command, d[20]);
			compare_field("command_code", want.command_code, d[28:21]);
			compare_field("zero_fill", 0, d[OUT_DATA_W-1:29]);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [BYTE_W-1:0]     cfg_wdata;

	frame_scoreboard sb = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int cfg_writes = 0;

	ascii_hex_checksum_frame_receiver u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver side, with an optional long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tlast);
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(b);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [BYTE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [BYTE_W-1:0] rs, input logic [BYTE_W-1:0] cs,
			input logic [BYTE_W-1:0] ec);
		drain();
		write_reg(REG_RESP_START, rs);
		write_reg(REG_CMD_START, cs);
		write_reg(REG_END_CHAR, ec);
	endtask

	function automatic logic [BYTE_W-1:0] pick_plain();
		logic [BYTE_W-1:0] v;
		do v = BYTE_W'($urandom_range(255));
		while (v == sb.resp_char || v == sb.cmd_char || v == sb.end_char);
		return v;
	endfunction

	// start byte, payload, two hex checksum characters, end byte
	task automatic send_frame(input logic [BYTE_W-1:0] lead, input int n, input bit corrupt);
		logic [BYTE_W-1:0] s;
		logic [BYTE_W-1:0] p;
		logic [BYTE_W-1:0] lo;
		s = lead;
		send_byte(lead);
		repeat (n) begin
			p = pick_plain();
			s = s + p;
			send_byte(p);
		end
		lo = sb.hex_of(s[3:0]);
		if (corrupt) begin
			lo = lo ^ (8'h01 << $urandom_range(7));
		end
		send_byte(sb.hex_of(s[7:4]));
		send_byte(lo);
		send_byte(sb.end_char);
	endtask

	task automatic random_traffic(input int target);
		int unsigned       first_req;
		int                pick;
		int                n;
		logic [BYTE_W-1:0] lead;
		first_req = sb.requests;
		while (sb.requests - first_req < target) begin
			pick = $urandom_range(99);
			n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
			lead = $urandom_range(1) ? sb.cmd_char : sb.resp_char;
			if (pick < 70) begin
				send_frame(lead, n, 1'b0);
			end else if (pick < 80) begin
				send_frame(lead, n, 1'b1);
			end else if (pick < 90) begin
				send_byte(lead);
				repeat ($urandom_range(2)) send_byte(BYTE_W'($urandom_range(255)));
				send_byte(sb.end_char);
			end else begin
				repeat ($urandom_range(6, 1)) send_byte(BYTE_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] rs;
		logic [BYTE_W-1:0] cs;
		logic [BYTE_W-1:0] ec;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RESP_START;
		cfg_wdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part on reset register values
		send_byte(END_CHAR_RST);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(RESP_START_RST, 2, 1'b0);
		send_frame(CMD_START_RST, 0, 1'b0);
		send_byte(CMD_START_RST);
		send_byte(END_CHAR_RST);
		send_byte(CMD_START_RST);
		send_byte(8'h55);
		send_byte(END_CHAR_RST);
		send_frame(RESP_START_RST, 1, 1'b1);
		// command start changed while a frame is open
		send_byte(CMD_START_RST);
		send_byte(8'h22);
		drain();
		write_reg(REG_CMD_START, 8'h99);
		send_byte(END_CHAR_RST);
		// both start registers equal, then end equal as well
		drain();
		write_reg(REG_RESP_START, 8'h99);
		send_byte(8'h99);
		send_byte(8'h99);
		send_byte(END_CHAR_RST);
		drain();
		write_reg(REG_END_CHAR, 8'h99);
		send_byte(8'h99);

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 61;
				end
				default: begin
					send_idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			if (p == 0) begin
				set_config(RESP_START_RST, CMD_START_RST, END_CHAR_RST);
			end else if (p == 1) begin
				set_config(8'h00, 8'hFF, 8'h80);
			end else if (p == 2) begin
				set_config(8'hFF, 8'h00, 8'h7F);
			end else begin
				rs = BYTE_W'($urandom_range(255));
				cs = ($urandom_range(3) == 0) ? rs : BYTE_W'($urandom_range(255));
				ec = ($urandom_range(7) == 0) ? cs : BYTE_W'($urandom_range(255));
				set_config(rs, cs, ec);
			end
			if (p == 2) begin
				hold_left = 400;
			end
			if (p == 5) begin
				send_frame(sb.cmd_char, 1030, 1'b0);
			end
			random_traffic(30);
			drain();
			random_traffic(30);
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Run covered %0d bytes and %0d register writes over eight settings",
			sb.requests, cfg_writes);
		$display("Frames closed: %0d, good checksum: %0d, saturated length: %0d",
			sb.frames_closed, sb.frames_good, sb.frames_long);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
